### sv/ecag_pkg.sv
// Package with shared types, constants and the rule lookup for the CA generation unit.
package ecag_pkg;

   localparam int unsigned TopBit     = 7;
   localparam int unsigned CellCount  = TopBit + 1;
   localparam logic [7:0]  RuleReset  = 8'd30;
   localparam int unsigned CsrAddrW   = 3;
   localparam int unsigned CsrDataW   = 32;
   localparam logic        RegRule    = 1'b0;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueAw    = $clog2(QueueDepth);
   localparam int unsigned QueueCw    = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [TopBit:0] data;
      logic            last;
   } ecag_result_type;

   typedef struct packed {
      logic            valid;
      ecag_result_type result;
   } ecag_beat_type;

   typedef struct packed {
      ecag_beat_type held;
      ecag_beat_type tail;
   } ecag_push_type;

   function automatic logic [TopBit:0] ecag_next_byte(
      input logic [TopBit:0] cur,
      input logic            left_in,
      input logic            right_in,
      input logic [7:0]      rule
   );
      logic [TopBit+2:0] line;
      logic [TopBit:0]   result;
      line = {right_in, cur, left_in};
      for (int k = 0; k < CellCount; k++) begin
         result[k] = rule[{line[k], line[k+1], line[k+2]}];
      end
      return result;
   endfunction

endpackage

### sv/ecag_csr.sv
// Configuration register file holding the rule number.
module ecag_csr import ecag_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready,
   output logic [7:0]          rule
);

   logic [7:0] rule_ff;
   logic [7:0] rule_in;
   logic       wr_rule;

   assign csr_pready = 1'b1;
   assign wr_rule = csr_psel && csr_penable && csr_pwrite && csr_pready
                    && (csr_paddr[CsrAddrW-1] == RegRule);
   assign rule_in = wr_rule ? csr_pwdata[7:0] : rule_ff;
   assign rule = rule_ff;

   always_comb begin
      unique case (csr_paddr[CsrAddrW-1])
         RegRule: csr_prdata = {{(CsrDataW-8){1'b0}}, rule_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff <= RuleReset;
      end else begin
         rule_ff <= rule_in;
      end
   end

endmodule

### sv/ecag_core.sv
// Line state and rule evaluation for each accepted byte.
module ecag_core import ecag_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [TopBit:0] in_byte,
   input  logic            in_last,
   input  logic [7:0]      rule,
   output ecag_push_type   push
);

   logic [TopBit:0] held_byte_ff;
   logic [TopBit:0] held_byte_in;
   logic            held_valid_ff;
   logic            held_valid_in;
   logic            left_cell_ff;
   logic            left_cell_in;
   logic            tail_left;

   assign tail_left = held_valid_ff ? held_byte_ff[TopBit] : left_cell_ff;

   always_comb begin
      push.held.valid       = accept && held_valid_ff;
      push.held.result.data = ecag_next_byte(held_byte_ff, left_cell_ff, in_byte[0], rule);
      push.held.result.last = 1'b0;
      push.tail.valid       = accept && in_last;
      push.tail.result.data = ecag_next_byte(in_byte, tail_left, 1'b0, rule);
      push.tail.result.last = 1'b1;
   end

   always_comb begin
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      left_cell_in  = left_cell_ff;
      if (accept) begin
         if (in_last) begin
            held_byte_in  = '0;
            held_valid_in = 1'b0;
            left_cell_in  = 1'b0;
         end else begin
            held_byte_in  = in_byte;
            held_valid_in = 1'b1;
            left_cell_in  = tail_left;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
         left_cell_ff  <= 1'b0;
      end else begin
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         left_cell_ff  <= left_cell_in;
      end
   end

endmodule

### sv/ecag_queue.sv
// Small result queue that takes up to two results per cycle and hands out one.
module ecag_queue import ecag_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ecag_push_type   push,
   input  logic            pop,
   output ecag_result_type head,
   output logic            not_empty,
   output logic            has_room
);

   ecag_result_type      slots_ff [QueueDepth];
   logic [QueueAw-1:0]   wr_ptr_ff;
   logic [QueueAw-1:0]   wr_ptr_in;
   logic [QueueAw-1:0]   rd_ptr_ff;
   logic [QueueAw-1:0]   rd_ptr_in;
   logic [QueueCw-1:0]   count_ff;
   logic [QueueCw-1:0]   count_in;
   logic [1:0]           n_push;
   logic                 both;
   ecag_result_type      first_res;
   logic                 first_valid;

   assign both        = push.held.valid && push.tail.valid;
   assign first_valid = push.held.valid || push.tail.valid;
   assign first_res   = push.held.valid ? push.held.result : push.tail.result;
   assign n_push      = {1'b0, push.held.valid} + {1'b0, push.tail.valid};

   assign not_empty = (count_ff != '0);
   assign has_room  = (count_ff <= QueueCw'(QueueDepth - 2));
   assign head      = slots_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + QueueAw'(n_push);
   assign rd_ptr_in = rd_ptr_ff + QueueAw'(pop);
   assign count_in  = count_ff + QueueCw'(n_push) - QueueCw'(pop);

   always_ff @(posedge clock) begin
      if (first_valid) begin
         slots_ff[wr_ptr_ff] <= first_res;
      end
      if (both) begin
         slots_ff[wr_ptr_ff + QueueAw'(1)] <= push.tail.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/elementary_ca_generation_unit.sv
// Top level of the elementary cellular automaton generation unit.
// Each byte but the last of a line is released by the transfer of the next byte;
// the last byte releases its own result and that of any held byte. Throughput is
// one byte per cycle while results are taken, set by the four-entry result queue,
// which takes an input while it holds at most two results. Synchronous reset clears
// the line state and the queue and sets the rule to 30.
module elementary_ca_generation_unit import ecag_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] in_byte
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [7:0] out_byte
   output logic                rsp_tlast,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   logic            accept;
   logic            pop;
   logic [7:0]      rule;
   ecag_push_type   push;
   ecag_result_type head;

   assign accept    = req_tvalid && req_tready;
   assign pop       = rsp_tvalid && rsp_tready;
   assign rsp_tdata = head.data;
   assign rsp_tlast = head.last;

   ecag_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .rule        (rule)
   );

   ecag_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .rule    (rule),
      .push    (push)
   );

   ecag_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (rsp_tvalid),
      .has_room  (req_tready)
   );

endmodule

### sv/ecag_checker.sv
// Port-level checks for the CA generation unit and their binding to the top level.
module ecag_checker import ecag_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [7:0]          rsp_tdata,
   input logic                rsp_tlast,
   input logic                csr_psel,
   input logic                csr_penable,
   input logic                csr_pwrite,
   input logic [CsrAddrW-1:0] csr_paddr,
   input logic [CsrDataW-1:0] csr_pwdata,
   input logic [CsrDataW-1:0] csr_prdata,
   input logic                csr_pready
);

   logic wr_rule;

   assign wr_rule = csr_psel && csr_penable && csr_pwrite && csr_pready
                    && (csr_paddr[CsrAddrW-1] == RegRule);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Stalled result transfer changed.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result offered right after reset.");

   a_pready: assert property (@(posedge clock)
      csr_pready)
      else $error("Configuration port not ready.");

   a_rule_readback: assert property (@(posedge clock) disable iff (reset)
      wr_rule ##1 (csr_paddr[CsrAddrW-1] == RegRule)
      |-> csr_prdata == {{(CsrDataW-8){1'b0}}, $past(csr_pwdata[7:0])})
      else $error("Rule register read back differs from the written value.");

endmodule

bind elementary_ca_generation_unit ecag_checker u_ecag_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tlast   (rsp_tlast),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);

### verif/tb_top.sv
// Self-checking testbench for the elementary cellular automaton generation unit.
module tb_top;
   import ecag_pkg::*;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   localparam int unsigned CycleLimit   = 200000;
   localparam int unsigned DrainCycles  = 4;
   localparam int unsigned RandomItems  = 600;
   localparam int unsigned PhaseItems   = 75;
   localparam int unsigned RegStride    = 4;
   localparam logic [CsrAddrW-1:0] RuleAddr  = CsrAddrW'(RegStride * RegRule);
   localparam logic [CsrAddrW-1:0] SpareAddr = RuleAddr + CsrAddrW'(RegStride);

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata   = '0;   // [7:0] in_byte
   logic                req_tlast   = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [7:0]          rsp_tdata;          // [7:0] out_byte
   logic                rsp_tlast;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr   = '0;
   logic [CsrDataW-1:0] csr_pwdata  = '0;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   logic [7:0]      rule_model;
   logic [TopBit:0] held_cells;
   logic            held_full;
   logic            left_edge;
   ecag_result_type expected_bytes[$];

   int unsigned    failures    = 0;
   int unsigned    cycle_count = 0;
   int unsigned    stall_left  = 0;
   stall_mode_type stall_mode  = STALL_NONE;
   bit             gaps_on     = 1'b1;
   int unsigned    burst_left  = 0;

   elementary_ca_generation_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else begin
         rsp_tready = 1'b1;
         case (stall_mode)
            STALL_LIGHT: begin
               if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 2);
            end
            STALL_HEAVY: begin
               if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(3, 8);
            end
            default: ;
         endcase
      end
   end

   function automatic logic [TopBit:0] next_generation_byte(
      input logic [TopBit:0] cells,
      input logic            left_nb,
      input logic            right_nb,
      input logic [7:0]      rule
   );
      logic [TopBit+2:0] row;
      logic [TopBit:0]   nxt;
      logic [2:0]        hood;
      row = {right_nb, cells, left_nb};
      for (int k = 0; k <= TopBit; k++) begin
         hood   = {row[k], row[k+1], row[k+2]};
         nxt[k] = rule[hood];
      end
      return nxt;
   endfunction

   task automatic predict_transfer(input logic [7:0] in_byte, input logic in_last);
      ecag_result_type res;
      if (held_full) begin
         res.data = next_generation_byte(held_cells, left_edge, in_byte[0], rule_model);
         res.last = 1'b0;
         expected_bytes.insert(expected_bytes.size(), res);
         left_edge = held_cells[TopBit];
      end
      if (in_last) begin
         res.data = next_generation_byte(in_byte, left_edge, 1'b0, rule_model);
         res.last = 1'b1;
         expected_bytes.insert(expected_bytes.size(), res);
         held_cells = '0;
         held_full  = 1'b0;
         left_edge  = 1'b0;
      end else begin
         held_cells = in_byte;
         held_full  = 1'b1;
      end
   endtask

   always @(posedge clock) begin : result_check
      ecag_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            $error("out_byte expected none got %02h", rsp_tdata);
            failures++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.data) begin
               $error("out_byte expected %02h got %02h", want.data, rsp_tdata);
               failures++;
            end
            if (rsp_tlast !== want.last) begin
               $error("out_last expected %0b got %0b", want.last, rsp_tlast);
               failures++;
            end
         end
      end
   end

   task automatic send_item(input logic [7:0] in_byte, input logic in_last);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = in_byte;
      req_tlast  = in_last;
      do @(posedge clock); while (!req_tready);
      predict_transfer(in_byte, in_last);
   endtask

   task automatic idle_sender(input int unsigned cycles);
      @(negedge clock);
      req_tvalid = 1'b0;
      req_tdata  = 8'($urandom);
      req_tlast  = 1'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_idle();
      idle_sender(1);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrAddrW-1:0] addr, input logic [CsrDataW-1:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr / RegStride == RegRule) rule_model = data[7:0];
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic csr_check_rule();
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = RuleAddr;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CsrDataW'(rule_model)) begin
         $error("rule_number expected %02h got %08h", rule_model, csr_prdata);
         failures++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_rule(input logic [7:0] rule);
      csr_write(RuleAddr, {(CsrDataW-8)'($urandom), rule});
      csr_check_rule();
   endtask

   task automatic test_boundary_lines();
      csr_check_rule();
      send_item(8'h01, 1'b1);
      send_item(8'h80, 1'b0);
      send_item(8'h01, 1'b1);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      wait_idle();
   endtask

   task automatic test_rule_writes();
      set_rule(8'hFF);
      send_item(8'h00, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h00, 1'b1);
      wait_idle();
      set_rule(8'h00);
      send_item(8'hFF, 1'b1);
      wait_idle();
      set_rule(8'd90);
      csr_write(SpareAddr, CsrDataW'(8'h00));
      csr_check_rule();
      send_item(8'hFF, 1'b0);
      send_item(8'h7E, 1'b1);
      wait_idle();
      set_rule(8'd110);
      send_item(8'h5A, 1'b0);
      wait_idle();
      // The new rule must also apply to the byte that is already held.
      set_rule(8'd184);
      send_item(8'hA5, 1'b0);
      send_item(8'h3C, 1'b1);
      wait_idle();
   endtask

   task automatic test_random_stream();
      int unsigned line_left;
      int unsigned phase;
      line_left = 0;
      for (int unsigned n = 0; n < RandomItems; n++) begin
         if (n % PhaseItems == 0) begin
            phase = n / PhaseItems;
            wait_idle();
            case (phase)
               0:       set_rule(8'h00);
               1:       set_rule(8'hFF);
               2:       set_rule(RuleReset);
               default: set_rule(8'($urandom_range(0, 255)));
            endcase
            stall_mode = stall_mode_type'(phase % 3);
            gaps_on    = (phase % 4 != 2);
            burst_left = 0;
         end
         if (line_left == 0) begin
            if ($urandom_range(0, 9) == 0) line_left = 1;
            else if ($urandom_range(0, 7) == 0) line_left = $urandom_range(9, 40);
            else line_left = $urandom_range(2, 8);
         end
         if (gaps_on) begin
            if (burst_left == 0) begin
               idle_sender($urandom_range(1, 6));
               burst_left = $urandom_range(1, 12);
            end
            burst_left--;
         end
         line_left--;
         send_item(8'($urandom_range(0, 255)), line_left == 0);
      end
      if (line_left != 0) send_item(8'($urandom_range(0, 255)), 1'b1);
      wait_idle();
   endtask

   initial begin
      rule_model = RuleReset;
      held_cells = '0;
      held_full  = 1'b0;
      left_edge  = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_boundary_lines();
      test_rule_writes();
      test_random_stream();
      if (failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### sim.f
sv/ecag_pkg.sv
sv/ecag_csr.sv
sv/ecag_core.sv
sv/ecag_queue.sv
sv/elementary_ca_generation_unit.sv
sv/ecag_checker.sv
verif/tb_top.sv
